>>> rtl/gaps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gaps_pkg: shared constants for the grid path search
// Status codes, grid limits and the neighbor step tables.
// ----------------------------------------------------------------------------
package gaps_pkg;
  localparam int unsigned GridDimDefault = 8;
  localparam int unsigned MaxExpDefault  = 64;

  localparam logic [1:0] StatusGoal    = 2'd0;
  localparam logic [1:0] StatusPartial = 2'd1;
  localparam logic [1:0] StatusNoPath  = 2'd2;

  // neighbor order W, E, +z, -z, NE, NW, SW, SE
  function automatic logic signed [1:0] step_dx(input logic [2:0] d);
    unique case (d)
      3'd0: step_dx = -2'sd1;
      3'd1: step_dx = 2'sd1;
      3'd2: step_dx = 2'sd0;
      3'd3: step_dx = 2'sd0;
      3'd4: step_dx = 2'sd1;
      3'd5: step_dx = -2'sd1;
      3'd6: step_dx = -2'sd1;
      default: step_dx = 2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] step_dz(input logic [2:0] d);
    unique case (d)
      3'd0: step_dz = 2'sd0;
      3'd1: step_dz = 2'sd0;
      3'd2: step_dz = 2'sd1;
      3'd3: step_dz = -2'sd1;
      3'd4: step_dz = -2'sd1;
      3'd5: step_dz = -2'sd1;
      3'd6: step_dz = 2'sd1;
      default: step_dz = 2'sd1;
    endcase
  endfunction
endpackage
`default_nettype wire

>>> rtl/grid_astar_path_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_astar_path_search: A* search on an 8-connected obstacle grid
// Loads obstacle rows, then searches and emits the path goal-to-start.
// ----------------------------------------------------------------------------
// Usage: a load item (kind_i=0) is taken in its accept cycle and leaves busy
// low, so the next item may follow at once. A search item holds busy for the
// whole run. Each expansion scans the open list through the open-list and f
// memories, shifts the picked entry out by moving each later entry down one
// slot and walks eight neighbors. Each usable neighbor needs a g read and an
// open-list scan. Path cells then stream out on result_valid_o; the receiver
// cannot stall, so every result is taken in its single strobe cycle.
// Configuration writes are accepted whenever the block is idle
// (cfg_ready_o = !busy).
// ----------------------------------------------------------------------------
module grid_astar_path_search
  import gaps_pkg::*;
#(
  parameter int unsigned GridDim = GridDimDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       kind_i,
  input  wire logic [2:0] row_index_i,
  input  wire logic [7:0] row_blocked_i,
  input  wire logic [2:0] start_x_i,
  input  wire logic [2:0] start_z_i,
  input  wire logic [2:0] goal_x_i,
  input  wire logic [2:0] goal_z_i,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [6:0] cfg_data_i,
  output logic            result_valid_o,
  output logic [2:0]      point_x_o,
  output logic [2:0]      point_z_o,
  output logic [1:0]      status_o,
  output logic            last_o
);
  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_SCANW = 4'd2,
                         S_PICK = 4'd3, S_SHIFT = 4'd4, S_NB = 4'd5,
                         S_NBG = 4'd6, S_NBO = 4'd7, S_NBOW = 4'd8,
                         S_NBUP = 4'd9, S_EMIT = 4'd10, S_EMITW = 4'd11,
                         S_FAIL = 4'd12, S_CUR = 4'd13, S_SCANF = 4'd14;

  // obstacle map and closed flags: flip-flops with reset
  logic [7:0]  blk_q [8];
  logic [63:0] closed_q;
  // search memories, synchronous read
  logic [7:0] g_mem [64];
  logic [7:0] f_mem [64];
  logic [5:0] cf_mem [64];
  logic [5:0] ol_mem [64];

  logic [3:0] st_q;
  logic [6:0] maxexp_q, exp_q, cnt_q, idx_q, best_q;
  logic [7:0] bestf_q, gcur_q, tent_q;
  logic [5:0] cur_q, s_q, goal_q, nb_q, bestc_q;
  logic [2:0] gx_q, gz_q, dir_q;
  logic       inopen_q;
  logic [1:0] stat_q;

  logic [7:0] f_rd, g_rd;
  logic [5:0] cf_rd, ol_rd;
  logic [5:0] f_ra, g_ra, cf_ra, ol_ra;

  assign busy = (st_q != S_IDLE);
  assign cfg_ready_o = !busy;

  function automatic logic blocked(input logic [2:0] x, input logic [2:0] z);
    logic [7:0] r;
    r = blk_q[z];
    blocked = r[x];
  endfunction

  function automatic logic [7:0] heur(input logic [2:0] x, input logic [2:0] z,
                                      input logic [2:0] gx, input logic [2:0] gz);
    logic [2:0] dx, dz;
    dx = (x > gx) ? x - gx : gx - x;
    dz = (z > gz) ? z - gz : gz - z;
    heur = {2'b0, 6'(dx) * 6'(dx)} + {2'b0, 6'(dz) * 6'(dz)};
  endfunction

  // neighbor coordinates of the current node
  logic signed [4:0] nxs, nzs;
  logic        nb_ok;
  logic [2:0]  nx, nz;
  logic [5:0]  nb_id;
  logic [8:0]  tsum, fsum;
  always_comb begin
    nxs = $signed({2'b0, cur_q[2:0]}) + 5'(step_dx(dir_q));
    nzs = $signed({2'b0, cur_q[5:3]}) + 5'(step_dz(dir_q));
    nx = nxs[2:0];
    nz = nzs[2:0];
    nb_id = {nz, nx};
    nb_ok = (nxs >= 0) && (nzs >= 0) && (nxs < 5'(GridDim)) && (nzs < 5'(GridDim));
    nb_ok = nb_ok && !blocked(nx, nz) && !closed_q[nb_id];
    tsum = {1'b0, gcur_q} + ((dir_q[2]) ? 9'd2 : 9'd1);
    fsum = {1'b0, tent_q} + {1'b0, heur(nb_q[2:0], nb_q[5:3], gx_q, gz_q)};
  end

  // memory read addresses
  logic [6:0] idx_nx, idx_pv, best_nx;
  always_comb begin
    idx_nx  = idx_q + 7'd1;
    idx_pv  = idx_q - 7'd1;
    best_nx = best_q + 7'd1;
    f_ra  = ol_rd;
    cf_ra = cur_q;
    // the shift reads one entry ahead of the entry it writes
    unique case (st_q)
      S_PICK: begin
        ol_ra = best_nx[5:0];
        g_ra  = bestc_q;
      end
      S_SHIFT: begin
        ol_ra = idx_nx[5:0];
        g_ra  = cur_q;
      end
      default: begin
        ol_ra = idx_q[5:0];
        g_ra  = nb_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ol_rd <= ol_mem[ol_ra];
    f_rd  <= f_mem[f_ra];
    g_rd  <= g_mem[g_ra];
    cf_rd <= cf_mem[cf_ra];
  end

  logic ol_we, gf_we, cf_we;
  logic [5:0] ol_wa, gf_wa;
  logic [5:0] ol_wd;
  logic [7:0] g_wd, f_wd;
  logic [5:0] cf_wd;
  always_ff @(posedge clk_i) begin
    if (ol_we) ol_mem[ol_wa] <= ol_wd;
    if (gf_we) begin
      g_mem[gf_wa] <= g_wd;
      f_mem[gf_wa] <= f_wd;
    end
    if (cf_we) cf_mem[gf_wa] <= cf_wd;
  end

  logic in_acc;
  assign in_acc = start && !busy;
  logic bad;
  assign bad = (start_x_i >= 3'(GridDim - 1) + 3'd1 && GridDim < 8) ||
               (start_z_i >= 3'(GridDim - 1) + 3'd1 && GridDim < 8) ||
               (goal_x_i >= 3'(GridDim - 1) + 3'd1 && GridDim < 8) ||
               (goal_z_i >= 3'(GridDim - 1) + 3'd1 && GridDim < 8) ||
               blocked(start_x_i, start_z_i) || blocked(goal_x_i, goal_z_i);

  // combinational write controls
  always_comb begin
    ol_we = 1'b0; ol_wa = idx_q[5:0]; ol_wd = 6'd0;
    gf_we = 1'b0; cf_we = 1'b0; gf_wa = nb_q;
    g_wd = tent_q; f_wd = fsum[8] ? 8'hFF : fsum[7:0]; cf_wd = cur_q;
    if (in_acc && kind_i && !bad) begin
      ol_we = 1'b1; ol_wa = 6'd0; ol_wd = {start_z_i, start_x_i};
      gf_we = 1'b1; cf_we = 1'b1; gf_wa = {start_z_i, start_x_i};
      g_wd = 8'd0; f_wd = heur(start_x_i, start_z_i, goal_x_i, goal_z_i);
      cf_wd = {start_z_i, start_x_i};
    end else if (st_q == S_SHIFT) begin
      // move entry idx down into idx-1
      if (idx_q < cnt_q) begin
        ol_we = 1'b1; ol_wa = idx_pv[5:0]; ol_wd = ol_rd;
      end
    end else if (st_q == S_NBUP) begin
      // write back only a new or improved neighbor
      if (!inopen_q || (tent_q < g_rd)) begin
        gf_we = 1'b1; cf_we = 1'b1;
      end
      if (!inopen_q) begin
        ol_we = 1'b1; ol_wa = cnt_q[5:0]; ol_wd = nb_q;
      end
    end
  end

  integer k;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      for (k = 0; k < 8; k++) blk_q[k] <= 8'd0;
      closed_q <= '0;
      maxexp_q <= 7'(MaxExpDefault);
      result_valid_o <= 1'b0;
      cnt_q <= '0; idx_q <= '0; exp_q <= '0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) maxexp_q <= cfg_data_i;
      unique case (st_q)
        S_IDLE: if (in_acc) begin
          if (!kind_i) begin
            if (32'(row_index_i) < GridDim) blk_q[row_index_i] <= row_blocked_i;
          end else if (bad) begin
            st_q <= S_FAIL;
          end else begin
            s_q <= {start_z_i, start_x_i};
            goal_q <= {goal_z_i, goal_x_i};
            gx_q <= goal_x_i; gz_q <= goal_z_i;
            closed_q <= '0; cnt_q <= 7'd1; exp_q <= '0;
            idx_q <= '0; bestf_q <= 8'hFF; best_q <= '0;
            st_q <= S_SCAN;
          end
        end
        // scan: ol read at idx lands, then f read lands
        S_SCAN: st_q <= S_SCANF;
        S_SCANF: st_q <= S_SCANW;
        S_SCANW: begin
          if (idx_q == 7'd0 || f_rd < bestf_q) begin
            bestf_q <= f_rd; best_q <= idx_q; bestc_q <= f_ra;
          end
          if (idx_q + 7'd1 < cnt_q) begin
            idx_q <= idx_q + 7'd1; st_q <= S_SCAN;
          end else st_q <= S_PICK;
        end
        S_PICK: begin
          cur_q <= bestc_q;
          if (bestc_q == goal_q) begin
            stat_q <= StatusGoal; st_q <= S_EMIT;
          end else if (exp_q >= maxexp_q) begin
            stat_q <= StatusPartial; st_q <= S_EMIT;
          end else begin
            closed_q[bestc_q] <= 1'b1;
            exp_q <= exp_q + 7'd1;
            idx_q <= best_q + 7'd1;
            st_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // ol_rd holds entry at idx (read last cycle); write it to idx-1
          if (idx_q < cnt_q) begin
            idx_q <= idx_q + 7'd1;
          end else begin
            cnt_q <= cnt_q - 7'd1;
            gcur_q <= g_rd; dir_q <= '0; st_q <= S_NB;
          end
        end
        S_NB: begin
          if (nb_ok) begin
            nb_q <= nb_id;
            tent_q <= tsum[8] ? 8'hFF : tsum[7:0];
            idx_q <= '0; inopen_q <= 1'b0;
            st_q <= S_NBG;
          end else if (dir_q == 3'd7) begin
            st_q <= (cnt_q == 7'd0) ? S_FAIL : S_CUR;
          end else dir_q <= dir_q + 3'd1;
        end
        S_NBG: st_q <= (cnt_q == 7'd0) ? S_NBOW : S_NBO;
        S_NBO: st_q <= S_NBOW;
        S_NBOW: begin
          if (cnt_q != 7'd0 && ol_rd == nb_q && idx_q < cnt_q) inopen_q <= 1'b1;
          if (idx_q + 7'd1 < cnt_q && !(ol_rd == nb_q)) begin
            idx_q <= idx_q + 7'd1; st_q <= S_NBO;
          end else st_q <= S_NBUP;
        end
        S_NBUP: begin
          if (!inopen_q) cnt_q <= cnt_q + 7'd1;
          if (dir_q == 3'd7) st_q <= S_CUR;
          else begin dir_q <= dir_q + 3'd1; st_q <= S_NB; end
        end
        S_CUR: begin
          idx_q <= '0; bestf_q <= 8'hFF;
          st_q <= (cnt_q == 7'd0) ? S_FAIL : S_SCAN;
        end
        S_EMIT: st_q <= S_EMITW;
        S_EMITW: begin
          result_valid_o <= 1'b1;
          point_x_o <= cur_q[2:0]; point_z_o <= cur_q[5:3];
          status_o <= stat_q;
          last_o <= (cur_q == s_q);
          if (cur_q == s_q) st_q <= S_IDLE;
          else begin cur_q <= cf_rd; st_q <= S_EMIT; end
        end
        S_FAIL: begin
          result_valid_o <= 1'b1;
          point_x_o <= '0; point_z_o <= '0;
          status_o <= StatusNoPath; last_o <= 1'b1;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  property p_res_idle;
    @(posedge clk_i) disable iff (!rst_ni) (result_valid_o && last_o) |-> !busy;
  endproperty
  a_res_idle: assert property (p_res_idle) else $error("last result while busy");

  a_no_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !cfg_ready_o) else $error("cfg ready while busy");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 7'd64) else $error("open count overflow");
endmodule
`default_nettype wire

>>> bench/tb_grid_astar_path_search.sv
// ----------------------------------------------------------------------------
// tb_grid_astar_path_search: self-checking bench for the grid path search
// Drives obstacle loads and searches through the start/busy port and the
// expansion limit through the cfg port. A scoreboard replays every accepted
// item on its own A* search and checks each path cell as it streams out.
// ----------------------------------------------------------------------------
module tb_grid_astar_path_search;
  timeunit 1ns;
  timeprecision 1ps;
  import gaps_pkg::*;

  localparam int unsigned IdleLimit = 400000;
  localparam int unsigned DrainCycles = 40;
  localparam logic KindLoad   = 1'b0;
  localparam logic KindSearch = 1'b1;
  localparam logic [6:0] LimitMin = 7'd1;
  localparam logic [6:0] LimitMax = 7'd64;

  typedef struct packed {
    logic [2:0] px;
    logic [2:0] pz;
    logic [1:0] st;
    logic       lst;
  } path_point_t;

  // Scoreboard: holds its own copy of the obstacle map and the expansion
  // limit, plans each search and queues the cells it should produce.
  class path_board;
    logic [7:0]  obstacle_rows [8];
    int          exp_limit;
    path_point_t pending_points [$];
    int          mismatches;
    int          step_x [8] = '{-1, 1, 0, 0, 1, -1, -1, 1};
    int          step_z [8] = '{0, 0, 1, -1, -1, -1, 1, 1};
    int          step_w [8] = '{1, 1, 1, 1, 2, 2, 2, 2};
    int          g_val [64];
    int          f_val [64];
    int          parent [64];
    bit          done_cell [64];
    int          frontier [64];
    int          frontier_len;

    function new();
      foreach (obstacle_rows[r]) obstacle_rows[r] = '0;
      exp_limit = 64;
      mismatches = 0;
    endfunction

    function void set_limit(logic [6:0] v);
      exp_limit = int'(v);
    endfunction

    function bit wall(int x, int z);
      return obstacle_rows[z][x];
    endfunction

    function int dist2(int x, int z, int gx, int gz);
      return (x - gx) * (x - gx) + (z - gz) * (z - gz);
    endfunction

    // Append one expected cell at the tail of the queue.
    function void add_point(path_point_t p);
      pending_points.insert(pending_points.size(), p);
    endfunction

    function void push_cell(int c, logic [1:0] st);
      path_point_t p;
      p.px = 3'(c % 8);
      p.pz = 3'(c / 8);
      p.st = st;
      p.lst = 1'b0;
      add_point(p);
    endfunction

    // Note one accepted item: a load updates the map, a search is planned.
    function void note_item(logic kind, logic [2:0] row, logic [7:0] mask,
                            logic [2:0] sx, logic [2:0] sz,
                            logic [2:0] gx, logic [2:0] gz);
      int s, goal, cur, best, nx, nz, nb, tent, n;
      bit in_open, found;
      logic [1:0] st;
      path_point_t np;
      if (kind == KindLoad) begin
        obstacle_rows[row] = mask;
        return;
      end
      if (wall(sx, sz) || wall(gx, gz)) begin
        np = '{px: 3'd0, pz: 3'd0, st: StatusNoPath, lst: 1'b1};
        add_point(np);
        return;
      end
      s = sz * 8 + sx;
      goal = gz * 8 + gx;
      foreach (done_cell[i]) done_cell[i] = 1'b0;
      g_val[s] = 0;
      f_val[s] = dist2(sx, sz, gx, gz);
      parent[s] = s;
      frontier[0] = s;
      frontier_len = 1;
      n = 0;  // expansions so far
      found = 1'b0;
      st = StatusGoal;
      cur = s;
      while (frontier_len > 0 && !found) begin
        best = 0;
        for (int i = 1; i < frontier_len; i++)
          if (f_val[frontier[i]] < f_val[frontier[best]]) best = i;
        cur = frontier[best];
        if (cur == goal) begin
          st = StatusGoal;
          found = 1'b1;
        end else if (n >= exp_limit) begin
          st = StatusPartial;
          found = 1'b1;
        end else begin
          for (int i = best; i < frontier_len - 1; i++) frontier[i] = frontier[i + 1];
          frontier_len--;
          done_cell[cur] = 1'b1;
          n++;
          for (int d = 0; d < 8; d++) begin
            nx = cur % 8 + step_x[d];
            nz = cur / 8 + step_z[d];
            if (nx < 0 || nz < 0 || nx > 7 || nz > 7) continue;
            if (wall(nx, nz)) continue;
            nb = nz * 8 + nx;
            if (done_cell[nb]) continue;
            tent = g_val[cur] + step_w[d];
            if (tent > 255) tent = 255;
            in_open = 1'b0;
            for (int j = 0; j < frontier_len; j++)
              if (frontier[j] == nb) in_open = 1'b1;
            if (!in_open || tent < g_val[nb]) begin
              parent[nb] = cur;
              g_val[nb] = tent;
              f_val[nb] = tent + dist2(nx, nz, gx, gz);
              if (f_val[nb] > 255) f_val[nb] = 255;
              if (!in_open && frontier_len < 64) begin
                frontier[frontier_len] = nb;
                frontier_len++;
              end
            end
          end
        end
      end
      if (!found) begin
        np = '{px: 3'd0, pz: 3'd0, st: StatusNoPath, lst: 1'b1};
        add_point(np);
        return;
      end
      // walk back from the reached cell to the start
      for (int k = 0; k < 64; k++) begin
        push_cell(cur, st);
        if (cur == s) break;
        cur = parent[cur];
      end
      pending_points[$].lst = 1'b1;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_point(path_point_t got);
      path_point_t want;
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("unexpected cell (%0d,%0d) st=%0d last=%0d",
                                  got.px, got.pz, got.st, got.lst));
        return;
      end
      want = pending_points.pop_front();
      if (got.px !== want.px)
        report_mismatch($sformatf("point_x %0d, want %0d", got.px, want.px));
      if (got.pz !== want.pz)
        report_mismatch($sformatf("point_z %0d, want %0d", got.pz, want.pz));
      if (got.st !== want.st)
        report_mismatch($sformatf("status %0d, want %0d", got.st, want.st));
      if (got.lst !== want.lst)
        report_mismatch($sformatf("last %0d, want %0d", got.lst, want.lst));
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       kind_i = 1'b0;
  logic [2:0] row_index_i = '0;
  logic [7:0] row_blocked_i = '0;
  logic [2:0] start_x_i = '0;
  logic [2:0] start_z_i = '0;
  logic [2:0] goal_x_i = '0;
  logic [2:0] goal_z_i = '0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [6:0] cfg_data_i = '0;
  logic       result_valid_o;
  logic [2:0] point_x_o;
  logic [2:0] point_z_o;
  logic [1:0] status_o;
  logic       last_o;

  path_board board = new();
  int unsigned quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  grid_astar_path_search dut (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .row_index_i, .row_blocked_i,
    .start_x_i, .start_z_i, .goal_x_i, .goal_z_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .result_valid_o, .point_x_o, .point_z_o, .status_o, .last_o
  );

  // Check every strobed path cell; the receiver never stalls.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      board.check_point('{px: point_x_o, pz: point_z_o, st: status_o, lst: last_o});
  end

  // Watchdog: count edges with no transfer on any port.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Often no gap, else mostly short gaps, now and then a long one.
  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return;
    start <= 1'b0;
    if (r < 9) repeat ($urandom_range(1, 3)) @(posedge clk_i);
    else repeat ($urandom_range(10, 40)) @(posedge clk_i);
  endtask

  // Present one item and hold it until the block takes the transfer.
  task automatic send_item(logic kind, logic [2:0] row, logic [7:0] mask,
                           logic [2:0] sx, logic [2:0] sz,
                           logic [2:0] gx, logic [2:0] gz);
    start <= 1'b1;
    kind_i <= kind;
    row_index_i <= row;
    row_blocked_i <= mask;
    start_x_i <= sx;
    start_z_i <= sz;
    goal_x_i <= gx;
    goal_z_i <= gz;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_item(kind, row, mask, sx, sz, gx, gz);
    idle_gap();
  endtask

  task automatic load_row(logic [2:0] row, logic [7:0] mask);
    send_item(KindLoad, row, mask, '0, '0, '0, '0);
  endtask

  task automatic search(logic [2:0] sx, logic [2:0] sz, logic [2:0] gx, logic [2:0] gz);
    send_item(KindSearch, 3'($urandom()), 8'($urandom()), sx, sz, gx, gz);
  endtask

  // Drain all expected cells, then let a trailing load finish.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending_points.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write the expansion limit only once the block is idle.
  task automatic write_limit(logic [6:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_limit(v);
    cfg_valid_i <= 1'b0;
  endtask

  // Random phase: mostly searches over a sparse map, some loads.
  task automatic random_phase(int count, bit hold_off);
    logic [7:0] mask;
    for (int i = 0; i < count; i++) begin
      if (hold_off && $urandom_range(0, 3) == 0) wait_drained();
      if ($urandom_range(0, 9) < 3) begin
        case ($urandom_range(0, 5))
          0: mask = '0;
          1: mask = 8'($urandom());
          default: mask = 8'($urandom() & $urandom() & $urandom());
        endcase
        load_row(3'($urandom()), mask);
      end else begin
        search(3'($urandom()), 3'($urandom()), 3'($urandom()), 3'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_limit(LimitMax);
    // Open grid: corner to corner, and a search that starts on its goal.
    search(3'd0, 3'd0, 3'd7, 3'd7);
    search(3'd3, 3'd3, 3'd3, 3'd3);
    // Full row of obstacles: goal blocked, start blocked, then a path below it.
    load_row(3'd7, 8'hFF);
    search(3'd0, 3'd0, 3'd7, 3'd7);
    search(3'd2, 3'd7, 3'd0, 3'd0);
    search(3'd7, 3'd0, 3'd0, 3'd6);
    // Box in the origin: no path.
    load_row(3'd0, 8'h02);
    load_row(3'd1, 8'h03);
    search(3'd0, 3'd0, 3'd5, 3'd5);
    // Both orthogonal cells blocked: the diagonal still cuts the corner.
    load_row(3'd1, 8'h01);
    search(3'd0, 3'd0, 3'd1, 3'd1);
    search(3'd0, 3'd0, 3'd6, 3'd6);
    load_row(3'd0, 8'h00);
    load_row(3'd1, 8'h00);
    load_row(3'd7, 8'h00);

    // Tightest limit: partial paths, and a search that starts on its goal.
    write_limit(LimitMin);
    search(3'd0, 3'd0, 3'd7, 3'd7);
    search(3'd7, 3'd7, 3'd0, 3'd0);
    search(3'd4, 3'd4, 3'd4, 3'd4);
    random_phase(30, 1'b0);

    write_limit(7'($urandom_range(2, 63)));
    search(3'd0, 3'd7, 3'd7, 3'd0);
    random_phase(35, 1'b1);

    write_limit(LimitMax);
    random_phase(35, 1'b0);

    write_limit(7'($urandom_range(1, 64)));
    random_phase(25, 1'b0);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_points.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/gaps_pkg.sv
rtl/grid_astar_path_search.sv
bench/tb_grid_astar_path_search.sv
